// File: hw/rtl/assert_macros.svh
// Assertion macros used by the heap priority queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert that expression holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Assert that consequent holds in the cycle after antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/mhpq_pkg.sv
// Package with constants, types and the rank compare of the heap priority queue.
package mhpq_pkg;

  localparam int CAPACITY     = 1024;
  localparam int NAME_LETTERS = 10;
  localparam int LETTER_BITS  = 5;
  localparam int KEY_W        = LETTER_BITS * NAME_LETTERS;
  localparam int ID_W         = 16;
  localparam int IDX_W        = $clog2(CAPACITY);
  localparam int CNT_W        = IDX_W + 1;

  typedef enum logic [1:0] {
    KIND_PUSH   = 2'd0,
    KIND_POP    = 2'd1,
    KIND_MODIFY = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POP_RD,
    S_POP_LD,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
  } entry_t;

  function automatic logic ranks_above(entry_t a, entry_t b);
    logic r;
    if (a.key != b.key) r = (a.key > b.key);
    else                r = (a.id < b.id);
    return r;
  endfunction

endpackage

// File: hw/rtl/max_heap_priority_queue.sv
// Binary max-heap priority queue with push, pop, modify-key and clear commands.
//
// Input channel (in_*): one command per transfer. in_tuser carries the kind
// (push, pop, modify, clear), in_tdata the item id and the packed name key.
// Result channel (out_*): exactly one result per command, in order, with the
// popped id in out_tdata and the status in out_tuser.
// Commands run one at a time through a sequencer around a single entry
// memory with two registered read ports and one write port, and the rank
// compare logic. in_tready is high only while the sequencer is idle.
// Push sifts the new entry up from the end of the heap, moving each parent
// that it ranks above down one level (at most log2 of capacity, 10 levels).
// Pop reads the root and the last entry, returns the root id, and sifts the
// last entry down from the root. Clear, push when full and pop when empty go
// straight to the final state. Modify searches the entries linearly for the
// matching id, then sifts the entry with its new key up and then down; a
// miss ends the search once every entry has been read.
// Reset empties the heap at once; entry contents need no clearing.
// A stalled result is held in the output register; the next command is
// still taken, and its result waits in the final state until the output
// register frees.
module max_heap_priority_queue
  import mhpq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,  // [15:0] item_id, [65:16] name_packed, rest zero
  input  logic [1:0]  in_tuser,  // [1:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata, // [15:0] popped_id
  output logic [1:0]  out_tuser  // [1:0] status
);

  `include "assert_macros.svh"

  entry_t heap_r [CAPACITY];
  entry_t rd_a_r, rd_b_r;
  logic [IDX_W-1:0] rd_a_addr, rd_b_addr, wr_addr;
  entry_t wr_data;
  logic wr_en;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  entry_t cur_r, cur_nxt;
  logic mod_r, mod_nxt;
  logic [ID_W-1:0] res_id_r, res_id_nxt;
  status_t res_st_r, res_st_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [ID_W-1:0] out_id_r, out_id_nxt;
  status_t out_st_r, out_st_nxt;

  logic [CNT_W:0] left, right;
  logic [CNT_W-1:0] parent;
  logic lv, rv, take_l, take_r;
  entry_t best;
  entry_t in_entry;

  always_ff @(posedge clk) begin
    if (wr_en) heap_r[wr_addr] <= wr_data;
    rd_a_r <= heap_r[rd_a_addr];
    rd_b_r <= heap_r[rd_b_addr];
  end

  assign in_entry.key = in_tdata[65:16];
  assign in_entry.id  = in_tdata[15:0];
  assign in_tready    = (state_r == S_IDLE);
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_id_r;
  assign out_tuser    = out_st_r;

  assign left   = {pos_r, 1'b1};
  assign right  = left + 1'b1;
  assign parent = (pos_r - 1'b1) >> 1;
  assign lv     = (left < {1'b0, count_r});
  assign rv     = (right < {1'b0, count_r});
  assign take_l = lv && ranks_above(rd_a_r, cur_r);
  assign best   = take_l ? rd_a_r : cur_r;
  assign take_r = rv && ranks_above(rd_b_r, best);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r    <= pos_nxt;
    idx_r    <= idx_nxt;
    cur_r    <= cur_nxt;
    mod_r    <= mod_nxt;
    res_id_r <= res_id_nxt;
    res_st_r <= res_st_nxt;
    out_id_r <= out_id_nxt;
    out_st_r <= out_st_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    cur_nxt       = cur_r;
    mod_nxt       = mod_r;
    res_id_nxt    = res_id_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_id_nxt    = out_id_r;
    out_st_nxt    = out_st_r;
    rd_a_addr     = '0;
    rd_b_addr     = '0;
    wr_en         = 1'b0;
    wr_addr       = pos_r[IDX_W-1:0];
    wr_data       = cur_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          res_id_nxt = '0;
          res_st_nxt = ST_OK;
          mod_nxt    = 1'b0;
          cur_nxt    = in_entry;
          idx_nxt    = '0;
          unique case (kind_t'(in_tuser))
            KIND_PUSH: begin
              if (count_r == CNT_W'(CAPACITY)) begin
                res_st_nxt = ST_FULL;
                state_nxt  = S_FIN;
              end else begin
                pos_nxt   = count_r;
                count_nxt = count_r + 1'b1;
                state_nxt = S_UP_RD;
              end
            end
            KIND_POP: begin
              if (count_r == '0) begin
                res_st_nxt = ST_EMPTY;
                state_nxt  = S_FIN;
              end else begin
                state_nxt = S_POP_RD;
              end
            end
            KIND_MODIFY: begin
              mod_nxt   = 1'b1;
              state_nxt = S_SRCH_RD;
            end
            KIND_CLEAR: begin
              count_nxt = '0;
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_POP_RD: begin
        rd_a_addr = '0;
        rd_b_addr = IDX_W'(count_r - 1'b1);
        state_nxt = S_POP_LD;
      end
      S_POP_LD: begin
        res_id_nxt = rd_a_r.id;
        count_nxt  = count_r - 1'b1;
        cur_nxt    = rd_b_r;
        pos_nxt    = '0;
        state_nxt  = S_DN_RD;
      end
      S_SRCH_RD: begin
        rd_a_addr = idx_r[IDX_W-1:0];
        if (idx_r == count_r) begin
          res_st_nxt = ST_NOT_FOUND;
          state_nxt  = S_FIN;
        end else begin
          state_nxt = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        if (rd_a_r.id == cur_r.id) begin
          pos_nxt   = idx_r;
          state_nxt = S_UP_RD;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SRCH_RD;
        end
      end
      S_UP_RD: begin
        rd_a_addr = parent[IDX_W-1:0];
        if (pos_r == '0) begin
          if (mod_r) begin
            state_nxt = S_DN_RD;
          end else begin
            wr_en     = 1'b1;
            state_nxt = S_FIN;
          end
        end else begin
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (ranks_above(cur_r, rd_a_r)) begin
          wr_en     = 1'b1;
          wr_data   = rd_a_r;
          pos_nxt   = parent;
          state_nxt = S_UP_RD;
        end else if (mod_r) begin
          state_nxt = S_DN_RD;
        end else begin
          wr_en     = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_DN_RD: begin
        rd_a_addr = left[IDX_W-1:0];
        rd_b_addr = right[IDX_W-1:0];
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        wr_en = 1'b1;
        if (take_r) begin
          wr_data   = rd_b_r;
          pos_nxt   = right[CNT_W-1:0];
          state_nxt = S_DN_RD;
        end else if (take_l) begin
          wr_data   = rd_a_r;
          pos_nxt   = left[CNT_W-1:0];
          state_nxt = S_DN_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = res_id_r;
          out_st_nxt    = res_st_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= CNT_W'(CAPACITY), "count over capacity")
  `ASSERT_ALWAYS(a_no_write_idle, clk, rst_n, !(wr_en && state_r == S_IDLE), "write while idle")
  `ASSERT_NEXT(a_fin_loads, clk, rst_n, state_r == S_FIN && (!out_valid_r || out_tready),
    out_valid_r && state_r == S_IDLE, "result not loaded")
  `ASSERT_NEXT(a_accept_busy, clk, rst_n, in_tvalid && in_tready, !in_tready, "accept not busy")

endmodule
